@@ sv/thbf_pkg.sv @@
// Shared constants and action codes for the two-hash Bloom filter.
package thbf_pkg;

  localparam int FILTER_BITS_DEF = 1024;

  // Seed of the first hash and shift behind both multipliers (33 = 32+1, 31 = 32-1)
  localparam int H1_SEED    = 5381;
  localparam int HASH_SHIFT = 5;

  // Bit array is held as rows of ROW_BITS bits
  localparam int ROW_LOG  = 5;
  localparam int ROW_BITS = 1 << ROW_LOG;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

endpackage

@@ sv/two_hash_bloom_filter.sv @@
// Top level of the two-hash Bloom filter: front end, command queue and bit-array engine.
//
// Key bytes are taken one per clock while start is high and busy is low; the two hashes
// update in the same cycle. The item that carries last_byte hands one command to a
// two-entry queue, and busy rises only while that queue is full or the array is cleared
// after reset. The bit array is a memory of FILTER_BITS/32 rows with two registered read
// ports and one write port; its engine reads both rows for each command, writes both rows
// of an insert or zeroes every row for a clear, and then goes idle for the next command.
// After reset the array is swept to zero (32 rows at default size) with busy held high.
// Each result appears for exactly one cycle on out_valid; the receiver cannot stall it.
module two_hash_bloom_filter import thbf_pkg::*; #(
  parameter int FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_key_byte,
  input  logic       in_has_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  output logic       out_maybe_present,
  output logic [1:0] out_done_action
);

  localparam int HW = $clog2(FILTER_BITS);
  localparam int QW = 2 + 2 * HW;

  logic          accept;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;
  logic [QW-1:0] q_head;
  logic          init_busy;

  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  thbf_front #(.FILTER_BITS(FILTER_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .key_byte  (in_key_byte),
    .has_byte  (in_has_byte),
    .last_byte (in_last_byte),
    .push      (q_push),
    .push_data (q_push_data)
  );

  thbf_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  thbf_back #(.FILTER_BITS(FILTER_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_not_empty),
    .cmd         (q_head),
    .pop         (q_pop),
    .init_busy   (init_busy),
    .res_valid   (out_valid),
    .res_present (out_maybe_present),
    .res_action  (out_done_action)
  );

  // a command is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // the engine only takes a command that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("command popped from empty queue");

  // the engine works on one command at a time, so results never come in adjacent cycles
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  // no result and no command taken while the array is still being swept after reset
  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !out_valid && !q_pop)
    else $error("activity during initial clear");

endmodule

@@ sv/thbf_front.sv @@
// Front end: folds key bytes into both hashes and issues one command per key.
module thbf_front import thbf_pkg::*; #(
  parameter int FILTER_BITS = FILTER_BITS_DEF,
  localparam int HW = $clog2(FILTER_BITS),
  localparam int QW = 2 + 2 * HW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    action,
  input  logic [7:0]    key_byte,
  input  logic          has_byte,
  input  logic          last_byte,
  output logic          push,
  output logic [QW-1:0] push_data
);

  localparam logic [HW-1:0] H1_START = HW'(H1_SEED % FILTER_BITS);

  logic [HW-1:0] h1_r, h1_nxt;
  logic [HW-1:0] h2_r, h2_nxt;
  logic [HW-1:0] h1_upd, h2_upd;
  logic [HW-1:0] h1_cur, h2_cur;
  logic [31:0]   char_ext;
  logic [HW-1:0] char_val;

  // Sign-extend as a C char, then keep the low hash bits
  assign char_ext = {{24{key_byte[7]}}, key_byte};
  assign char_val = char_ext[HW-1:0];

  assign h1_upd = (h1_r << HASH_SHIFT) + h1_r + char_val;
  assign h2_upd = (h2_r << HASH_SHIFT) - h2_r + char_val;

  assign h1_cur = has_byte ? h1_upd : h1_r;
  assign h2_cur = has_byte ? h2_upd : h2_r;

  assign push      = accept && last_byte;
  assign push_data = {action, h1_cur, h2_cur};

  always_comb begin
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    if (accept) begin
      if (last_byte) begin
        // restart both hashes for the next key
        h1_nxt = H1_START;
        h2_nxt = '0;
      end else begin
        h1_nxt = h1_cur;
        h2_nxt = h2_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= H1_START;
      h2_r <= '0;
    end else begin
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
    end
  end

endmodule

@@ sv/thbf_queue.sv @@
// Two-entry command queue between the front end and the bit-array engine.
module thbf_queue import thbf_pkg::*; #(
  parameter int W = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output logic [W-1:0] head
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/thbf_back.sv @@
// Back end: executes insert, query and clear commands on the row-organised bit array.
module thbf_back import thbf_pkg::*; #(
  parameter int FILTER_BITS = FILTER_BITS_DEF,
  localparam int HW   = $clog2(FILTER_BITS),
  localparam int QW   = 2 + 2 * HW,
  localparam int RAW  = HW - ROW_LOG,
  localparam int ROWS = FILTER_BITS >> ROW_LOG
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  logic [QW-1:0] cmd,
  output logic          pop,
  output logic          init_busy,
  output logic          res_valid,
  output logic          res_present,
  output logic [1:0]    res_action
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_SET1 = 3'd3;
  localparam logic [2:0] ST_SET2 = 3'd4;
  localparam logic [2:0] ST_WIPE = 3'd5;

  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

  logic [ROW_BITS-1:0] mem [ROWS];

  logic [2:0]          state_r, state_nxt;
  logic [RAW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]          act_r;
  logic [HW-1:0]       i1_r, i2_r;
  logic [ROW_BITS-1:0] rd1_r, rd2_r;
  logic                vld_r, vld_nxt;
  logic                pres_r, pres_nxt;
  logic [1:0]          ract_r, ract_nxt;

  logic [1:0]          q_act;
  logic [HW-1:0]       q_i1, q_i2;
  logic [RAW-1:0]      row1, row2;
  logic [ROW_LOG-1:0]  col1, col2;
  logic [ROW_BITS-1:0] bit1, bit2, row1_set, base2;
  logic                wr_en;
  logic [RAW-1:0]      wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  assign q_act = cmd[QW-1 -: 2];
  assign q_i1  = cmd[2*HW-1 -: HW];
  assign q_i2  = cmd[HW-1:0];

  assign row1 = i1_r[HW-1:ROW_LOG];
  assign row2 = i2_r[HW-1:ROW_LOG];
  assign col1 = i1_r[ROW_LOG-1:0];
  assign col2 = i2_r[ROW_LOG-1:0];
  assign bit1 = ROW_BITS'(1) << col1;
  assign bit2 = ROW_BITS'(1) << col2;

  assign row1_set = rd1_r | bit1;
  // second write must keep the first bit when both land in one row
  assign base2    = (row1 == row2) ? row1_set : rd2_r;

  assign pop       = (state_r == ST_IDLE) && cmd_valid;
  assign init_busy = (state_r == ST_INIT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = 1'b0;
    pres_nxt  = pres_r;
    ract_nxt  = ract_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r;
    wr_data   = '0;
    case (state_r)
      ST_INIT, ST_WIPE: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + RAW'(1);
        if (cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        vld_nxt  = 1'b1;
        pres_nxt = rd1_r[col1] & rd2_r[col2];
        ract_nxt = act_r;
        if (act_r == ACT_INSERT) begin
          state_nxt = ST_SET1;
        end else if (act_r == ACT_CLEAR) begin
          cnt_nxt   = '0;
          state_nxt = ST_WIPE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SET1: begin
        wr_en     = 1'b1;
        wr_addr   = row1;
        wr_data   = row1_set;
        state_nxt = ST_SET2;
      end
      ST_SET2: begin
        wr_en     = 1'b1;
        wr_addr   = row2;
        wr_data   = base2 | bit2;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pres_r <= pres_nxt;
    ract_r <= ract_nxt;
    if (pop) begin
      act_r <= q_act;
      i1_r  <= q_i1;
      i2_r  <= q_i2;
    end
  end

  // array: two registered reads on pop, one write port
  always_ff @(posedge clk) begin
    if (pop) begin
      rd1_r <= mem[q_i1[HW-1:ROW_LOG]];
      rd2_r <= mem[q_i2[HW-1:ROW_LOG]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign res_valid   = vld_r;
  assign res_present = pres_r;
  assign res_action  = ract_r;

endmodule

@@ tb/sv/two_hash_bloom_filter_tb.sv @@
// Self-checking testbench for the two-hash Bloom filter: directed keys, then random key streams.
module two_hash_bloom_filter_tb;
  import thbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         IDX_W      = $clog2(FILTER_BITS_DEF);
  localparam int         FIRST_MUL  = 33;
  localparam int         SECOND_MUL = 31;
  localparam logic [1:0] ACT_OTHER  = 2'd3;  // undefined code, behaves as a query
  localparam int         ITEM_COUNT = 550;
  localparam int         QUIET_FROM = 450;   // no gaps from here on
  localparam int         POOL_SIZE  = 8;

  typedef struct {
    bit         maybe_present;
    logic [1:0] action;
  } filter_answer_t;

  class bloom_scoreboard;
    bit [FILTER_BITS_DEF-1:0] filter_bits;
    bit [IDX_W-1:0]           first_hash;
    bit [IDX_W-1:0]           second_hash;
    filter_answer_t           pending_answers[$];
    int unsigned              mismatches;

    function new();
      filter_bits = '0;
      first_hash  = IDX_W'(H1_SEED);
      second_hash = '0;
      mismatches  = 0;
    endfunction

    function void note_request(logic [1:0] act, logic [7:0] key_byte, logic has, logic last);
      bit [31:0]      ext;
      bit [31:0]      sum1;
      bit [31:0]      sum2;
      filter_answer_t ans;
      if (has) begin
        ext = {{24{key_byte[7]}}, key_byte};
        sum1 = first_hash * FIRST_MUL + ext;
        sum2 = second_hash * SECOND_MUL + ext;
        first_hash  = sum1[IDX_W-1:0];
        second_hash = sum2[IDX_W-1:0];
      end
      if (!last) return;
      ans.maybe_present = filter_bits[first_hash] && filter_bits[second_hash];
      ans.action        = act;
      if (act == ACT_INSERT) begin
        filter_bits[first_hash]  = 1'b1;
        filter_bits[second_hash] = 1'b1;
      end else if (act == ACT_CLEAR) begin
        filter_bits = '0;
      end
      first_hash  = IDX_W'(H1_SEED);
      second_hash = '0;
      pending_answers.insert(pending_answers.size(), ans);
    endfunction

    function void check_result(logic present, logic [1:0] act);
      filter_answer_t ans;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no request waiting: maybe_present=%0b done_action=%0d",
                 $time, present, act);
        mismatches++;
        return;
      end
      ans = pending_answers.pop_front();
      if (present !== ans.maybe_present) begin
        $display("%0t: maybe_present expected %0b actual %0b", $time, ans.maybe_present, present);
        mismatches++;
      end
      if (act !== ans.action) begin
        $display("%0t: done_action expected %0d actual %0d", $time, ans.action, act);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_action;
  logic [7:0] in_key_byte;
  logic       in_has_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_maybe_present;
  logic [1:0] out_done_action;

  bloom_scoreboard sb = new();
  int              items_sent;
  bit [7:0]        key_pool[POOL_SIZE][$];

  two_hash_bloom_filter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_key_byte      (in_key_byte),
    .in_has_byte      (in_has_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_maybe_present(out_maybe_present),
    .out_done_action  (out_done_action)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_action, in_key_byte, in_has_byte, in_last_byte);
      if (out_valid) sb.check_result(out_maybe_present, out_done_action);
    end
  end

  task automatic send_request(logic [1:0] act, logic [7:0] key_byte, logic has, logic last);
    if (items_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_key_byte  <= key_byte;
    in_has_byte  <= has;
    in_last_byte <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (has || last) items_sent++;
  endtask

  // Stream one key; the action only matters on the closing request.
  task automatic send_key(logic [1:0] act, bit [7:0] key_bytes[$], bit end_with_byte,
                          bit add_noise);
    int n;
    n = key_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (add_noise && $urandom_range(0, 3) == 0)
        send_request(2'($urandom), 8'($urandom), 1'b0, 1'b0);
      if (i == n - 1 && end_with_byte)
        send_request(act, key_bytes[i], 1'b1, 1'b1);
      else
        send_request(2'($urandom), key_bytes[i], 1'b1, 1'b0);
    end
    if (n == 0 || !end_with_byte) send_request(act, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  initial begin
    bit [7:0]   key_bytes[$];
    bit [7:0]   empty_key[$];
    logic [1:0] act;
    int         pick;
    bit         drained;

    items_sent   = 0;
    drained      = 1'b0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_action    <= ACT_INSERT;
    in_key_byte  <= '0;
    in_has_byte  <= 1'b0;
    in_last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty keys, extreme bytes, every action, a noise request between keys
    send_key(ACT_QUERY, empty_key, 1'b0, 1'b0);
    send_key(ACT_INSERT, empty_key, 1'b0, 1'b0);
    send_key(ACT_QUERY, empty_key, 1'b0, 1'b0);
    send_key(ACT_OTHER, empty_key, 1'b0, 1'b0);
    key_bytes = {8'h00, 8'hFF};
    send_key(ACT_INSERT, key_bytes, 1'b1, 1'b0);
    send_key(ACT_QUERY, key_bytes, 1'b0, 1'b0);
    send_request(ACT_OTHER, 8'hFF, 1'b0, 1'b0);
    key_bytes = {8'h80, 8'h7F};
    send_key(ACT_QUERY, key_bytes, 1'b1, 1'b0);
    send_key(ACT_INSERT, key_bytes, 1'b1, 1'b0);
    send_key(ACT_OTHER, key_bytes, 1'b1, 1'b0);
    send_key(ACT_CLEAR, empty_key, 1'b0, 1'b0);
    send_key(ACT_QUERY, empty_key, 1'b0, 1'b0);
    key_bytes = {8'h00, 8'hFF};
    send_key(ACT_QUERY, key_bytes, 1'b1, 1'b0);

    for (int p = 0; p < POOL_SIZE; p++)
      repeat ($urandom_range(0, 6)) key_pool[p].insert(key_pool[p].size(), 8'($urandom));

    // Random: reuse pooled keys so that queries and repeat inserts hit set bits
    while (items_sent < ITEM_COUNT) begin
      if (!drained && items_sent >= 200) begin
        drain_answers();
        drained = 1'b1;
      end
      if ($urandom_range(0, 1) == 0) begin
        key_bytes = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        key_bytes = {};
        repeat ($urandom_range(0, 6)) key_bytes.insert(key_bytes.size(), 8'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      act = ACT_INSERT;
      else if (pick < 82) act = ACT_QUERY;
      else if (pick < 92) act = ACT_OTHER;
      else                act = ACT_CLEAR;
      send_key(act, key_bytes, 1'($urandom), $urandom_range(0, 2) == 0);
    end

    drain_answers();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/thbf_pkg.sv
sv/thbf_front.sv
sv/thbf_queue.sv
sv/thbf_back.sv
sv/two_hash_bloom_filter.sv
tb/sv/two_hash_bloom_filter_tb.sv
